@@ hdl/gf256_word_poly_inverse_top_assert.svh @@
// assertion macros for the word polynomial inverse block
// used by the checker module only
`ifndef GF256_WORD_POLY_INVERSE_TOP_ASSERT_SVH
`define GF256_WORD_POLY_INVERSE_TOP_ASSERT_SVH
`define GWPI_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define GWPI_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ hdl/gwpi_pkg.sv @@
// shared types, constants and gf(2^8) helpers for the word polynomial inverse
// no dependencies
package gwpi_pkg;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [8:0] FIELD_POLY = 9'h11B;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic  req;
        t_byte a;
        t_byte b;
    } t_mul_req;

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        logic [8:0] x;
        t_byte acc;
        acc = BYTE_ZERO;
        x = {1'b0, a};
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    function automatic t_byte gf_recip_calc(input t_byte a);
        t_byte r;
        t_byte base;
        r = BYTE_ONE;
        base = a;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) begin
                r = gf_mul(r, base);
            end
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    typedef t_byte t_recip_tab [256];

    function automatic t_recip_tab make_recip_tab();
        t_recip_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = gf_recip_calc(i[7:0]);
        end
        return t;
    endfunction

    localparam t_recip_tab RECIP_TAB = make_recip_tab();
endpackage

@@ hdl/gwpi_mul.sv @@
// registered gf(2^8) multiplier shared by all multiply steps of the sequencer
// depends on gwpi_pkg
module gwpi_mul (
    input  logic             i_clk,
    input  gwpi_pkg::t_mul_req i_req,
    output gwpi_pkg::t_byte  o_prod
);
    import gwpi_pkg::*;

    t_byte r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.req) begin
            r_prod <= gf_mul(i_req.a, i_req.b);
        end
    end

    assign o_prod = r_prod;
endmodule

@@ hdl/gf256_word_poly_inverse_top.sv @@
// a zero word goes straight from the round check to the finish step and the result strobe; each
// byte product on the shared registered gf(2^8) multiplier is requested in one state and taken
// up in a separate accumulate state, and every round ends with the bezout update. one beat at a
// time: busy is high until the strobe, and a new beat can be accepted in the strobe cycle.
// the receiver cannot stall.
// reset (synchronous, active low) returns the sequencer to idle.
module gf256_word_poly_inverse_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_poly_word,
    output logic        o_valid,
    output logic [31:0] o_inverse_word,
    output logic        o_invertible
);
    import gwpi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ROUND, S_DIVCHK, S_DIVMUL, S_DIVSUB, S_QMUL, S_QACC,
        S_SWAP, S_FIN, S_FMUL, S_FACC
    } t_state;

    t_state r_state;
    t_byte r_ra [5];
    t_byte r_rb [5];
    t_byte r_sa [4];
    t_byte r_sb [4];
    t_byte r_t  [4];
    t_byte r_q  [5];
    t_byte r_c;
    t_byte r_linv;
    logic [2:0] r_iter;
    logic [2:0] r_sh;
    logic [2:0] r_i;
    logic [1:0] r_j;
    logic [2:0] r_db;
    logic [31:0] r_res;
    logic r_ok;
    logic r_valid;
    t_mul_req mreq;
    t_byte prod;

    gwpi_mul u_mul (.i_clk(i_clk), .i_req(mreq), .o_prod(prod));

    logic [2:0] da;
    logic da_ok;
    logic [2:0] db;
    logic db_ok;

    always_comb begin
        da = 3'd0;
        da_ok = 1'b0;
        db = 3'd0;
        db_ok = 1'b0;
        for (int k = 0; k < 5; k++) begin
            if (r_ra[k] != BYTE_ZERO) begin
                da = k[2:0];
                da_ok = 1'b1;
            end
            if (r_rb[k] != BYTE_ZERO) begin
                db = k[2:0];
                db_ok = 1'b1;
            end
        end
    end

    always_comb begin
        mreq.req = 1'b0;
        mreq.a = r_c;
        mreq.b = r_rb[r_i];
        case (r_state)
            S_DIVCHK: begin
                mreq.req = 1'b1;
                mreq.a = r_ra[da];
                mreq.b = r_linv;
            end
            S_DIVMUL: begin
                mreq.req = 1'b1;
                mreq.a = (r_i == 3'd0) ? prod : r_c;
                mreq.b = r_rb[r_i];
            end
            S_QMUL: begin
                mreq.req = 1'b1;
                mreq.a = r_q[r_i];
                mreq.b = r_sb[r_j];
            end
            S_FMUL: begin
                mreq.req = 1'b1;
                mreq.a = r_sa[r_j];
                mreq.b = r_linv;
            end
            default: begin
                mreq.req = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_ra <= '{BYTE_ONE, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ONE};
                        r_rb <= '{i_poly_word[7:0], i_poly_word[15:8],
                                  i_poly_word[23:16], i_poly_word[31:24], BYTE_ZERO};
                        r_sa <= '{BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO};
                        r_sb <= '{BYTE_ONE, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO};
                        r_iter <= 3'd0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (!db_ok || r_iter == 3'd5) begin
                        r_state <= S_FIN;
                    end else begin
                        r_linv <= RECIP_TAB[r_rb[db]];
                        r_db <= db;
                        r_q <= '{BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO};
                        r_state <= S_DIVCHK;
                    end
                end
                S_DIVCHK: begin
                    if (da_ok && da >= r_db) begin
                        r_sh <= da - r_db;
                        r_i <= 3'd0;
                        r_state <= S_DIVMUL;
                    end else begin
                        r_t <= r_sa;
                        r_i <= 3'd0;
                        r_j <= 2'd0;
                        r_state <= S_QMUL;
                    end
                end
                S_DIVMUL: begin
                    if (r_i == 3'd0) begin
                        r_c <= prod;
                        r_q[r_sh] <= r_q[r_sh] ^ prod;
                    end
                    r_state <= S_DIVSUB;
                end
                S_DIVSUB: begin
                    r_ra[r_i + r_sh] <= r_ra[r_i + r_sh] ^ prod;
                    if (r_i == r_db) begin
                        r_state <= S_DIVCHK;
                    end else begin
                        r_i <= r_i + 3'd1;
                        r_state <= S_DIVMUL;
                    end
                end
                S_QMUL: begin
                    r_state <= S_QACC;
                end
                S_QACC: begin
                    r_t[r_i[1:0] + r_j] <= r_t[r_i[1:0] + r_j] ^ prod;
                    r_state <= S_QMUL;
                    if (r_j == 2'd3) begin
                        r_j <= 2'd0;
                        if (r_i == 3'd4) begin
                            r_state <= S_SWAP;
                        end else begin
                            r_i <= r_i + 3'd1;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_SWAP: begin
                    r_ra <= r_rb;
                    r_rb <= r_ra;
                    r_sa <= r_sb;
                    r_sb <= r_t;
                    r_iter <= r_iter + 3'd1;
                    r_state <= S_ROUND;
                end
                S_FIN: begin
                    r_res <= '0;
                    r_j <= 2'd0;
                    if (da_ok && da == 3'd0) begin
                        r_linv <= RECIP_TAB[r_ra[0]];
                        r_ok <= 1'b1;
                        r_state <= S_FMUL;
                    end else begin
                        r_ok <= 1'b0;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_FMUL: begin
                    r_state <= S_FACC;
                end
                S_FACC: begin
                    r_res[8*r_j +: 8] <= prod;
                    if (r_j == 2'd3) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_j <= r_j + 2'd1;
                        r_state <= S_FMUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_inverse_word = r_res;
    assign o_invertible = r_ok;
endmodule

@@ hdl/gwpi_checker.sv @@
// port-level checker for the word polynomial inverse block
// depends on the assertion macro header; bound to the top level
`include "gf256_word_poly_inverse_top_assert.svh"
module gwpi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_inverse_word,
    input logic        o_invertible
);
    `GWPI_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `GWPI_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `GWPI_ASSERT_IMP(a_zero_fail, i_clk, i_rst_n, o_valid && !o_invertible,
        o_inverse_word == 32'd0)
    `GWPI_ASSERT_NXT(a_single, i_clk, i_rst_n, o_valid, !o_valid)
endmodule

bind gf256_word_poly_inverse_top gwpi_checker u_gwpi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_inverse_word(o_inverse_word), .o_invertible(o_invertible)
);
